[rtl/core/tlpq_pkg.sv]
// Shared types, constants and helpers for the three-class priority queue.
// Depends on nothing; ctrl, datapath and top use it by scoped names, the bench imports it.
`timescale 1ns / 1ps

package tlpq_pkg;

    // Sizing of the queue storage
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int NUM_CLASSES = 3;
    localparam int RAM_DEPTH   = NUM_CLASSES * QUEUE_DEPTH;

    // Derived widths
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(RAM_DEPTH);
    localparam int CLS_W  = 2;
    localparam int PORT_TAG_W = 16;

    // Request codes
    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_DEQUEUE = 1'b1;

    // Class codes
    localparam logic [CLS_W-1:0] CLS_SERIOUS = 2'd0;
    localparam logic [CLS_W-1:0] CLS_MEDIUM  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_GENERAL = 2'd2;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status STAT_ENQUEUED = 2'd0;
    localparam t_status STAT_FULL     = 2'd1;
    localparam t_status STAT_SERVED   = 2'd2;
    localparam t_status STAT_EMPTY    = 2'd3;

    // Request and result payloads
    typedef struct packed {
        logic                  req_type;
        logic [CLS_W-1:0]      priority_class;
        logic [PORT_TAG_W-1:0] entry_tag;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [PORT_TAG_W-1:0] served_tag;
        logic [CLS_W-1:0]      served_class;
    } t_result;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic emit;
    } t_cmd;

    // Fit a port tag into the stored tag width
    function automatic logic [TAG_BITS-1:0] tag_in(input logic [PORT_TAG_W-1:0] t);
        logic [TAG_BITS+PORT_TAG_W-1:0] w;
        w = {{TAG_BITS{1'b0}}, t};
        return w[TAG_BITS-1:0];
    endfunction

    // Fit a stored tag onto the port tag width
    function automatic logic [PORT_TAG_W-1:0] tag_out(input logic [TAG_BITS-1:0] s);
        logic [TAG_BITS+PORT_TAG_W-1:0] w;
        w = {{PORT_TAG_W{1'b0}}, s};
        return w[PORT_TAG_W-1:0];
    endfunction

endpackage

[rtl/core/tlpq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module tlpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/tlpq_ctrl.sv]
// Request sequencer: takes a request, then presents its result for one cycle.
// Depends on tlpq_pkg.
`timescale 1ns / 1ps

module tlpq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_done,
    output tlpq_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic r_state;
    logic n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands and handshake
    assign busy         = (r_state != S_IDLE);
    assign o_cmd.accept = start && (r_state == S_IDLE);
    assign o_cmd.emit   = (r_state == S_RESP);
    assign o_done       = o_cmd.emit;

    // A result strobe always comes in the cycle after a transfer
    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_done)
        else $error("result strobe missing after transfer");

    a_no_accept_while_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_cmd.accept)
        else $error("transfer taken while result is shown");

endmodule

[rtl/core/tlpq_dp.sv]
// Queue datapath: per-class pointers and counts, shared tag RAM, result register.
// Depends on tlpq_pkg and tlpq_ram.
`timescale 1ns / 1ps

module tlpq_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlpq_pkg::t_cmd    i_cmd,
    input  tlpq_pkg::t_req    i_req,
    output tlpq_pkg::t_result o_result
);

    localparam int NC = tlpq_pkg::NUM_CLASSES;

    logic [NC-1:0][tlpq_pkg::PTR_W-1:0] r_head;
    logic [NC-1:0][tlpq_pkg::PTR_W-1:0] r_tail;
    logic [NC-1:0][tlpq_pkg::CNT_W-1:0] r_fill;

    logic [tlpq_pkg::CLS_W-1:0]  enq_cls;
    logic [tlpq_pkg::CLS_W-1:0]  deq_cls;
    logic [tlpq_pkg::CLS_W-1:0]  op_cls;
    logic                        is_deq;
    logic                        enq_full;
    logic                        any_held;
    logic [tlpq_pkg::PTR_W-1:0]  pos;
    logic [tlpq_pkg::PTR_W-1:0]  n_pos;
    logic [tlpq_pkg::ADDR_W-1:0] addr;
    logic                        wr_en;
    logic                        rd_en;
    tlpq_pkg::t_status           n_status;
    logic [tlpq_pkg::TAG_BITS-1:0] rd_data;

    tlpq_pkg::t_status           r_status;
    logic [tlpq_pkg::CLS_W-1:0]  r_class;

    // Map the unused class code onto the general class
    always_comb begin
        if (i_req.priority_class == tlpq_pkg::CLS_SERIOUS ||
            i_req.priority_class == tlpq_pkg::CLS_MEDIUM) begin
            enq_cls = i_req.priority_class;
        end else begin
            enq_cls = tlpq_pkg::CLS_GENERAL;
        end
    end

    // Pick the highest non-empty class for a dequeue
    always_comb begin
        any_held = 1'b1;
        priority if (r_fill[0] != '0) begin
            deq_cls = tlpq_pkg::CLS_SERIOUS;
        end else if (r_fill[1] != '0) begin
            deq_cls = tlpq_pkg::CLS_MEDIUM;
        end else if (r_fill[2] != '0) begin
            deq_cls = tlpq_pkg::CLS_GENERAL;
        end else begin
            deq_cls  = tlpq_pkg::CLS_SERIOUS;
            any_held = 1'b0;
        end
    end

    // Decide the operation and its RAM address
    assign is_deq   = (i_req.req_type == tlpq_pkg::REQ_DEQUEUE);
    assign enq_full = (r_fill[enq_cls] == tlpq_pkg::CNT_W'(tlpq_pkg::QUEUE_DEPTH));
    assign op_cls   = is_deq ? deq_cls : enq_cls;
    assign pos      = is_deq ? r_head[op_cls] : r_tail[op_cls];
    assign n_pos    = (pos == tlpq_pkg::PTR_W'(tlpq_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : pos + tlpq_pkg::PTR_W'(1);
    assign addr     = tlpq_pkg::ADDR_W'(op_cls) * tlpq_pkg::ADDR_W'(tlpq_pkg::QUEUE_DEPTH)
                      + tlpq_pkg::ADDR_W'(pos);
    assign wr_en    = i_cmd.accept && !is_deq && !enq_full;
    assign rd_en    = i_cmd.accept && is_deq && any_held;

    always_comb begin
        if (is_deq) begin
            n_status = any_held ? tlpq_pkg::STAT_SERVED : tlpq_pkg::STAT_EMPTY;
        end else begin
            n_status = enq_full ? tlpq_pkg::STAT_FULL : tlpq_pkg::STAT_ENQUEUED;
        end
    end

    // Advance pointers and counts of the touched class
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            for (int c = 0; c < NC; c++) begin
                if (wr_en && op_cls == tlpq_pkg::CLS_W'(c)) begin
                    r_tail[c] <= n_pos;
                    r_fill[c] <= r_fill[c] + tlpq_pkg::CNT_W'(1);
                end
                if (rd_en && op_cls == tlpq_pkg::CLS_W'(c)) begin
                    r_head[c] <= n_pos;
                    r_fill[c] <= r_fill[c] - tlpq_pkg::CNT_W'(1);
                end
            end
        end
    end

    // Hold the result code until it is shown
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status <= n_status;
            r_class  <= rd_en ? deq_cls : tlpq_pkg::CLS_SERIOUS;
        end
    end

    // Tag storage shared by all classes
    tlpq_ram #(
        .WIDTH (tlpq_pkg::TAG_BITS),
        .DEPTH (tlpq_pkg::RAM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (addr),
        .i_wr_data (tlpq_pkg::tag_in(i_req.entry_tag)),
        .i_rd_en   (rd_en),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    // Drive the result; tag and class are zero unless an entry was served
    always_comb begin
        o_result.status       = r_status;
        o_result.served_tag   = (r_status == tlpq_pkg::STAT_SERVED) ?
                                tlpq_pkg::tag_out(rd_data) : '0;
        o_result.served_class = r_class;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[0] <= tlpq_pkg::CNT_W'(tlpq_pkg::QUEUE_DEPTH) &&
        r_fill[1] <= tlpq_pkg::CNT_W'(tlpq_pkg::QUEUE_DEPTH) &&
        r_fill[2] <= tlpq_pkg::CNT_W'(tlpq_pkg::QUEUE_DEPTH))
        else $error("class count beyond queue depth");

    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("write and read in the same transfer");

    a_read_gives_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> r_status == tlpq_pkg::STAT_SERVED)
        else $error("read issued without served status");

    a_counts_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !wr_en && !rd_en |=> $stable(r_fill))
        else $error("class count changed without an operation");

endmodule

[rtl/core/three_level_priority_queue.sv]
// Top level of the three-class strict-priority queue.
// Depends on tlpq_pkg, tlpq_ctrl and tlpq_dp.
// Latency: the result strobe o_done is high in the cycle after the transfer.
// The sequencer takes no new request while it shows a result; busy is high then.
// Reset: synchronous, active low; clears all class counts and pointers, no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module three_level_priority_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  tlpq_pkg::t_req    i_req,
    output logic              busy,
    output logic              o_done,
    output tlpq_pkg::t_result o_result
);

    tlpq_pkg::t_cmd cmd;

    // Sequencer
    tlpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // Queue storage and result register
    tlpq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_result (o_result)
    );

endmodule

[tb/tb_three_level_priority_queue.sv]
// Self-checking bench for the three-class strict-priority queue: a directed
// table, then random bursts, checked against an in-bench queue predictor.
// Depends on tlpq_pkg and three_level_priority_queue.
`timescale 1ns / 1ps

module tb_three_level_priority_queue;
    import tlpq_pkg::*;

    // Unused class selector, stored as general
    localparam logic [CLS_W-1:0] CLS_SPARE = 2'd3;
    localparam int ITEMS_PER_PHASE = 350;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_req    i_req   = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    // Expectation typed into the directed table, carried with the request
    logic    row_pinned = 1'b0;
    t_result row_expect = '0;

    // Predictor copy of the queue state
    logic [TAG_BITS-1:0] model_tags [NUM_CLASSES][QUEUE_DEPTH];
    int model_head [NUM_CLASSES] = '{0, 0, 0};
    int model_tail [NUM_CLASSES] = '{0, 0, 0};
    int model_fill [NUM_CLASSES] = '{0, 0, 0};

    t_result pending_outcomes [$];
    int      fault_count = 0;

    typedef struct {
        t_req    req;
        int      reps;
        bit      pinned;
        t_result want;
    } stim_row_t;

    stim_row_t directed_rows [12];

    three_level_priority_queue u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Advance the predictor by one request and return its outcome
    function automatic t_result queue_outcome(input t_req r);
        t_result res;
        int      cls;
        int      pick;
        logic [TAG_BITS-1:0] held;
        res  = '0;
        pick = -1;
        if (r.req_type == REQ_ENQUEUE) begin
            if (r.priority_class == CLS_SPARE) begin
                cls = CLS_GENERAL;
            end else begin
                cls = r.priority_class;
            end
            if (model_fill[cls] >= QUEUE_DEPTH) begin
                res.status = STAT_FULL;
            end else begin
                model_tags[cls][model_tail[cls]] = TAG_BITS'(r.entry_tag);
                model_tail[cls] = (model_tail[cls] + 1) % QUEUE_DEPTH;
                model_fill[cls]++;
                res.status = STAT_ENQUEUED;
            end
        end else begin
            // Lowest non-empty class wins
            for (cls = NUM_CLASSES - 1; cls >= 0; cls--) begin
                if (model_fill[cls] != 0) pick = cls;
            end
            if (pick < 0) begin
                res.status = STAT_EMPTY;
            end else begin
                held = model_tags[pick][model_head[pick]];
                model_head[pick] = (model_head[pick] + 1) % QUEUE_DEPTH;
                model_fill[pick]--;
                res.status       = STAT_SERVED;
                res.served_tag   = PORT_TAG_W'(held);
                res.served_class = CLS_W'(pick);
            end
        end
        return res;
    endfunction

    // Record each request transfer, check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_result fresh;
        t_result due;
        if (i_rst_n) begin
            if (start === 1'b1 && busy === 1'b0) begin
                fresh = queue_outcome(i_req);
                if (row_pinned) fresh = row_expect;
                pending_outcomes.push_back(fresh);
            end
            if (o_done === 1'b1) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: unexpected result status %0d tag %h class %0d", $time,
                             o_result.status, o_result.served_tag, o_result.served_class);
                    fault_count++;
                end else begin
                    due = pending_outcomes.pop_front();
                    if (o_result.status !== due.status
                            || o_result.served_tag !== due.served_tag
                            || o_result.served_class !== due.served_class) begin
                        $display("%0t: mismatch: expected status %0d tag %h class %0d, got status %0d tag %h class %0d",
                                 $time, due.status, due.served_tag, due.served_class,
                                 o_result.status, o_result.served_tag, o_result.served_class);
                        fault_count++;
                    end
                end
            end else if (o_done !== 1'b0) begin
                $display("%0t: result strobe unknown: expected 0 or 1, got %b", $time, o_done);
                fault_count++;
            end
        end
    end

    // Hold a request until its transfer
    task automatic issue(input t_req r, input bit pin, input t_result w);
        i_req      <= r;
        start      <= 1'b1;
        row_pinned <= pin;
        row_expect <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Drop start with chance pct, and keep it low while further draws stay under pct
    task automatic idle_gap(input int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < pct);
        end
    endtask

    initial begin
        int   sender_pct [3];
        int   done_items;
        int   burst_len;
        int   enq_pct;
        t_req r;

        sender_pct = '{15, 66, 0};

        directed_rows = '{
            // dequeue straight after reset
            '{'{REQ_DEQUEUE, CLS_SERIOUS, 16'h0000}, 1, 1'b1, '{STAT_EMPTY, 16'h0, 2'd0}},
            // one entry per class, tag extremes, spare selector
            '{'{REQ_ENQUEUE, CLS_SERIOUS, 16'hFFFF}, 1, 1'b1, '{STAT_ENQUEUED, 16'h0, 2'd0}},
            '{'{REQ_ENQUEUE, CLS_MEDIUM, 16'h0000}, 1, 1'b1, '{STAT_ENQUEUED, 16'h0, 2'd0}},
            '{'{REQ_ENQUEUE, CLS_SPARE, 16'h5A5A}, 1, 1'b1, '{STAT_ENQUEUED, 16'h0, 2'd0}},
            // strict-priority drain; class and tag bits ignored on dequeue
            '{'{REQ_DEQUEUE, CLS_GENERAL, 16'h1234}, 1, 1'b1,
              '{STAT_SERVED, 16'hFFFF, CLS_SERIOUS}},
            '{'{REQ_DEQUEUE, CLS_SERIOUS, 16'h0000}, 1, 1'b1,
              '{STAT_SERVED, 16'h0000, CLS_MEDIUM}},
            '{'{REQ_DEQUEUE, CLS_MEDIUM, 16'h0000}, 1, 1'b1,
              '{STAT_SERVED, 16'h5A5A, CLS_GENERAL}},
            '{'{REQ_DEQUEUE, CLS_SPARE, 16'hFFFF}, 1, 1'b1, '{STAT_EMPTY, 16'h0, 2'd0}},
            // fill medium to the brim, then overflow it
            '{'{REQ_ENQUEUE, CLS_MEDIUM, 16'h8000}, QUEUE_DEPTH, 1'b0, '{STAT_ENQUEUED, 16'h0, 2'd0}},
            '{'{REQ_ENQUEUE, CLS_MEDIUM, 16'h7FFF}, 1, 1'b1, '{STAT_FULL, 16'h0, 2'd0}},
            // serve from the full medium queue, whose tail has wrapped
            '{'{REQ_DEQUEUE, CLS_SERIOUS, 16'h0000}, 1, 1'b0, '{STAT_EMPTY, 16'h0, 2'd0}},
            '{'{REQ_DEQUEUE, CLS_SERIOUS, 16'h0000}, 1, 1'b0, '{STAT_EMPTY, 16'h0, 2'd0}}
        };

        // Reset once
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (directed_rows[i]) begin
            for (int k = 0; k < directed_rows[i].reps; k++) begin
                r = directed_rows[i].req;
                r.entry_tag = directed_rows[i].req.entry_tag + 16'(k);
                issue(r, directed_rows[i].pinned, directed_rows[i].want);
                idle_gap(sender_pct[0]);
            end
        end

        // Random bursts: enqueue-heavy fills queues, balanced ones mix, dequeue-heavy drains them
        for (int phase = 0; phase < 3; phase++) begin
            done_items = 0;
            while (done_items < ITEMS_PER_PHASE) begin
                burst_len = $urandom_range(4, 40);
                case ($urandom_range(2))
                    0: enq_pct = 85;
                    1: enq_pct = 50;
                    default: enq_pct = 20;
                endcase
                for (int b = 0; b < burst_len && done_items < ITEMS_PER_PHASE; b++) begin
                    r.req_type       = ($urandom_range(99) < enq_pct) ? REQ_ENQUEUE
                                                                      : REQ_DEQUEUE;
                    r.priority_class = CLS_W'($urandom_range(3));
                    r.entry_tag      = PORT_TAG_W'($urandom);
                    issue(r, 1'b0, '0);
                    idle_gap(sender_pct[phase]);
                    done_items++;
                end
            end
        end

        // Drain outstanding results, then allow for stray strobes
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
